FILE: rtl/tisp_pkg.sv
package tisp_pkg;

   // Default pool geometry.
   localparam int NODE_COUNT_DEF    = 1024;
   localparam int ALPHABET_SIZE_DEF = 26;

   // Field widths of the channels.
   localparam int OP_W     = 2;
   localparam int LETTER_W = 5;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_PREFIX = 2'd2,
      OP_RSVD   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_END
   } state_type;

endpackage

FILE: rtl/tisp_if.sv
interface tisp_req_if import tisp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [LETTER_W-1:0] letter;
   logic                has_letter;
   logic                last;

   modport source (output valid, output operation, output letter, output has_letter,
                   output last, input ready);
   modport sink   (input valid, input operation, input letter, input has_letter,
                   input last, output ready);
endinterface

interface tisp_rsp_if import tisp_pkg::*; ();
   logic valid;
   logic ready;
   logic answer;
   logic pool_full;

   modport source (output valid, output answer, output pool_full, input ready);
   modport sink   (input valid, input answer, input pool_full, output ready);
endinterface

FILE: rtl/tisp_ram.sv
module tisp_ram import tisp_pkg::*; #(
   parameter int WIDTH = 1,
   parameter int DEPTH = NODE_COUNT_DEF,
   parameter int AW    = $clog2(NODE_COUNT_DEF)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/trie_insert_search_prefix.sv
// Prefix trie over a fixed pool of nodes, fed one letter per item.
//
// The req_ch channel carries one letter per item with its operation (insert,
// search, prefix), a has_letter flag that marks an empty word, and last on the
// final item of a word. Only a last item gives a result on rsp_ch: answer, and
// pool_full when an insert ran out of nodes. Items with the unused operation
// code, and empty-word items that are not last, are taken and dropped.
//
// Every child link of a node sits in one wide row of the link memory, so each
// letter costs one row read, followed by one row write-back when an insert
// adds a node. A last item then goes through an end-of-word state that reads
// the end-of-word mark of the node that the walk reached. The result is
// registered and shows on rsp_ch in the cycle after that state completes.
//
// After reset the block runs a clearing pass over both memories, one node per
// cycle, and holds req_ch.ready low until it is done.
// When the receiver stalls, the waiting result holds in its register and the
// block goes on taking items; only a second result waits until the first one
// has been taken.
module trie_insert_search_prefix import tisp_pkg::*; #(
   parameter int NODE_COUNT    = NODE_COUNT_DEF,
   parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tisp_req_if.sink   req_ch,
   tisp_rsp_if.source rsp_ch
);

   localparam int NODE_W  = $clog2(NODE_COUNT);
   localparam int FREE_W  = NODE_W + 1;
   localparam int ALPHA_W = $clog2(ALPHABET_SIZE);
   localparam int ROW_W   = ALPHABET_SIZE * NODE_W;

   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_COUNT - 1);
   localparam logic [FREE_W-1:0] POOL_SIZE = FREE_W'(NODE_COUNT);

   state_type state_ff, state_in;

   logic [NODE_W-1:0]   clr_ff, clr_in;
   logic [NODE_W-1:0]   cursor_ff, cursor_in;
   logic [FREE_W-1:0]   free_ff, free_in;
   logic                missed_ff, missed_in;
   logic                failed_ff, failed_in;

   op_type              op_ff;
   logic [LETTER_W-1:0] letter_ff;
   logic                has_ff;
   logic                last_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic answer_ff, answer_in;
   logic full_ff, full_in;

   logic req_fire;
   logic item_live;
   logic end_fire;
   logic stopped;

   logic [ALPHA_W-1:0] slot;
   logic [NODE_W-1:0]  link;
   logic               letter_ok;

   logic              row_we;
   logic [NODE_W-1:0] row_waddr;
   logic [ROW_W-1:0]  row_wdata;
   logic [ROW_W-1:0]  row_rdata;

   logic              mark_we;
   logic [NODE_W-1:0] mark_waddr;
   logic              mark_wdata;
   logic              mark_rdata;

   tisp_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NODE_COUNT),
      .AW    (NODE_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_waddr),
      .wr_data (row_wdata),
      .rd_addr (cursor_ff),
      .rd_data (row_rdata)
   );

   // The mark is read at the node the walk moves to, so it is ready for the
   // end-of-word cycle that follows.
   tisp_ram #(
      .WIDTH (1),
      .DEPTH (NODE_COUNT),
      .AW    (NODE_W)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_waddr),
      .wr_data (mark_wdata),
      .rd_addr (cursor_in),
      .rd_data (mark_rdata)
   );

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign item_live = (op_type'(req_ch.operation) != OP_RSVD) &&
                      (req_ch.has_letter || req_ch.last);
   assign end_fire  = (state_ff == ST_END) && (!rsp_valid_ff || rsp_ch.ready);
   assign stopped   = missed_ff || failed_ff;

   assign slot      = ALPHA_W'(letter_ff);
   assign letter_ok = 32'(letter_ff) < ALPHABET_SIZE;
   assign link      = row_rdata[slot*NODE_W +: NODE_W];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire && item_live) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            state_in = last_ff ? ST_END : ST_IDLE;
         end
         ST_END: begin
            if (end_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Outputs of the state machine and the walk datapath.
   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      clr_in       = clr_ff;
      cursor_in    = cursor_ff;
      free_in      = free_ff;
      missed_in    = missed_ff;
      failed_in    = failed_ff;
      row_we       = 1'b0;
      row_waddr    = cursor_ff;
      row_wdata    = row_rdata;
      mark_we      = 1'b0;
      mark_waddr   = cursor_ff;
      mark_wdata   = 1'b0;
      answer_in    = answer_ff;
      full_in      = full_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in     = clr_ff + NODE_W'(1);
            row_we     = 1'b1;
            row_waddr  = clr_ff;
            row_wdata  = '0;
            mark_we    = 1'b1;
            mark_waddr = clr_ff;
         end
         ST_IDLE: begin
         end
         ST_WALK: begin
            if (has_ff && !stopped) begin
               if (!letter_ok) begin
                  missed_in = 1'b1;
               end else if (link != '0) begin
                  cursor_in = link;
               end else if (op_ff != OP_INSERT) begin
                  missed_in = 1'b1;
               end else if (free_ff >= POOL_SIZE) begin
                  failed_in = 1'b1;
               end else begin
                  // Take a fresh node from the pool and hook it under the cursor.
                  row_we    = 1'b1;
                  row_wdata[slot*NODE_W +: NODE_W] = free_ff[NODE_W-1:0];
                  cursor_in = free_ff[NODE_W-1:0];
                  free_in   = free_ff + FREE_W'(1);
               end
            end
         end
         ST_END: begin
            if (end_fire) begin
               answer_in = 1'b0;
               full_in   = 1'b0;
               case (op_ff)
                  OP_INSERT: begin
                     answer_in  = !stopped;
                     full_in    = failed_ff;
                     mark_we    = !stopped;
                     mark_wdata = 1'b1;
                  end
                  OP_SEARCH: answer_in = !stopped && mark_rdata;
                  default:   answer_in = !stopped;
               endcase
               cursor_in = '0;
               missed_in = 1'b0;
               failed_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ch.ready) || end_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cursor_ff    <= '0;
         free_ff      <= FREE_W'(1);
         missed_ff    <= 1'b0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cursor_ff    <= cursor_in;
         free_ff      <= free_in;
         missed_ff    <= missed_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff     <= op_type'(req_ch.operation);
         letter_ff <= req_ch.letter;
         has_ff    <= req_ch.has_letter;
         last_ff   <= req_ch.last;
      end
      answer_ff <= answer_in;
      full_ff   <= full_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.answer    = answer_ff;
   assign rsp_ch.pool_full = full_ff;

endmodule
